### design/hsait_pkg.sv
// Shared types, constants and hash helpers of the hashed set-associative index table.
package hsait_pkg;

   localparam int KEY_W  = 32;
   localparam int VAL_W  = 40;
   localparam int OCC_W  = 14;
   localparam int LFSR_W = 32;

   localparam int DEF_LOG2_BUCKETS = 10;
   localparam int DEF_WAYS         = 8;

   // Operation codes carried in req_tuser.
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_ERASE  = 2'd2;
   localparam logic [1:0] KIND_NOP    = 2'd3;

   localparam int FLAG_GOOD = 0;
   localparam int FLAG_UPD  = 1;

   localparam logic [VAL_W-1:0]  EMPTY_VALUE = '1;
   localparam logic [KEY_W-1:0]  HASH_SEED   = 32'hdeadbeef;
   localparam logic [LFSR_W-1:0] LFSR_TAPS   = 32'h80200003;

   // The victim modulo retires this many dividend bits per cycle.
   localparam int MOD_STEP_BITS = 4;
   localparam int MOD_STEPS     = LFSR_W / MOD_STEP_BITS;
   localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

   localparam int REQ_TUSER_W = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_FIELD_W = 1 + VAL_W + 1 + 1 + OCC_W;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_HIT_BIT = 0;

   typedef struct packed {
      logic [1:0]       flags;
      logic [VAL_W-1:0] value;
      logic [KEY_W-1:0] key;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{flags: 2'b00, value: EMPTY_VALUE, key: '0};

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } hash_state_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
      return (x << k) | (x >> (32 - k));
   endfunction

   // First half of the final mix; b and c start from the seed, so c folds to a constant.
   function automatic hash_state_type hash_front(input logic [KEY_W-1:0] key);
      hash_state_type s;
      s.a = HASH_SEED + key;
      s.b = HASH_SEED;
      s.c = HASH_SEED ^ HASH_SEED;
      s.c = s.c - rotl32(HASH_SEED, 14);
      s.a = s.a ^ s.c;
      s.a = s.a - rotl32(s.c, 11);
      s.b = s.b ^ s.a;
      s.b = s.b - rotl32(s.a, 25);
      return s;
   endfunction

   function automatic logic [31:0] hash_back(input hash_state_type st);
      hash_state_type s;
      s = st;
      s.c = s.c ^ s.b;
      s.c = s.c - rotl32(s.b, 16);
      s.a = s.a ^ s.c;
      s.a = s.a - rotl32(s.c, 4);
      s.b = s.b ^ s.a;
      s.b = s.b - rotl32(s.a, 14);
      s.c = s.c ^ s.b;
      s.c = s.c - rotl32(s.b, 24);
      return s.c;
   endfunction

   function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] x);
      return x[0] ? ((x >> 1) ^ LFSR_TAPS) : (x >> 1);
   endfunction

endpackage

### design/hashed_set_assoc_index_table_core.sv
// Hashed set-associative index table: a bucket memory with read-modify-write per word.
//
// Each request word is a lookup, insert, erase or no-op on one bucket of WAYS entries, picked by the
// lookup3 final mix of the key. An item passes through the accept, the first hash stage, the
// second hash stage together with the bucket read, the compare, and the write-back with the
// result load, and the next word is taken in the cycle after its result is loaded. An insert
// into a full bucket adds a victim choice, where an iterative modulo unit reduces the 32-bit
// LFSR word four bits per cycle. The result register lets the next request be taken while a
// result still waits; a finished item holds in its last stage until the result register is
// free. After reset the block clears the bucket memory one row per cycle, all 2**LOG2_BUCKETS
// rows, before it takes the first word.
module hashed_set_assoc_index_table_core #(
   parameter int LOG2_BUCKETS = hsait_pkg::DEF_LOG2_BUCKETS,
   parameter int WAYS         = hsait_pkg::DEF_WAYS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // key [31:0], value [71:32], good [72], zeros above
   input  logic [hsait_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // kind [1:0]
   input  logic [hsait_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit [0], found_value [40:1], found_good [41], replaced [42], entry_count [56:43], zeros above
   output logic [hsait_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [hsait_pkg::LFSR_W-1:0]       csr_wr_data
);
   import hsait_pkg::*;

   localparam int BUCKETS = 1 << LOG2_BUCKETS;
   localparam int WAY_W   = $clog2(WAYS);
   localparam int CNT_W   = $clog2(WAYS + 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;
   localparam logic [2:0] ST_MOD   = 3'd5;
   localparam logic [2:0] ST_PICK  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   entry_type [WAYS-1:0] bucket_mem [BUCKETS];

   logic [2:0]              state_ff, state_in;
   logic [LOG2_BUCKETS-1:0] clr_addr_ff;
   logic [1:0]              kind_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [VAL_W-1:0]        value_ff;
   logic                    good_ff;
   hash_state_type          hs_ff;
   logic [LOG2_BUCKETS-1:0] bucket_ff;
   entry_type [WAYS-1:0]    rd_row_ff;
   entry_type [WAYS-1:0]    wr_row_ff;
   logic                    wr_pend_ff;
   logic                    res_hit_ff;
   logic [VAL_W-1:0]        res_fval_ff;
   logic                    res_fgood_ff;
   logic                    res_repl_ff;
   logic                    occ_inc_ff;
   logic                    occ_dec_ff;
   logic [WAYS-1:0]         ngmask_ff;
   logic                    use_ng_ff;
   logic [CNT_W-1:0]        divisor_ff;
   logic [LFSR_W-1:0]       dividend_ff;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [MOD_CNT_W-1:0]    mod_cnt_ff;
   logic [LFSR_W-1:0]       lfsr_ff, lfsr_in;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;

   logic                    req_accept;
   logic                    out_free;
   logic [31:0]             hash_c;
   logic                    rd_en;
   logic                    wr_en;
   logic [LOG2_BUCKETS-1:0] wr_addr;
   entry_type [WAYS-1:0]    wr_data;

   // Bucket scan
   logic [WAYS-1:0]         key_eq, era_eq, empty_w, ng_w;
   logic                    key_any, era_any, emp_any;
   logic [WAY_W-1:0]        key_idx, era_idx, emp_idx;
   logic [CNT_W-1:0]        ng_cnt;
   entry_type [WAYS-1:0]    exec_row;
   logic                    exec_hit, exec_fgood, exec_wr, exec_inc, exec_dec, need_victim;
   logic [VAL_W-1:0]        exec_fval;
   logic [LFSR_W-1:0]       lfsr_next;

   // Victim pick
   logic [WAYS-1:0]         below;
   logic [WAY_W-1:0]        victim;
   entry_type [WAYS-1:0]    pick_row;
   logic [CNT_W:0]          mod_t;
   logic [CNT_W-1:0]        mod_r;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign hash_c     = hash_back(hs_ff);
   assign lfsr_next  = lfsr_advance(lfsr_ff);
   assign occ_in     = occ_ff + OCC_W'(occ_inc_ff) - OCC_W'(occ_dec_ff);

   assign rd_en   = (state_ff == ST_READ);
   assign wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_DONE) && out_free && wr_pend_ff);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : bucket_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? {WAYS{EMPTY_ENTRY}} : wr_row_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= bucket_mem[hash_c[LOG2_BUCKETS-1:0]];
      end
      if (wr_en) begin
         bucket_mem[wr_addr] <= wr_data;
      end
   end

   // Scan all ways of the bucket; the lowest matching way wins.
   always_comb begin
      key_any = 1'b0;
      era_any = 1'b0;
      emp_any = 1'b0;
      key_idx = '0;
      era_idx = '0;
      emp_idx = '0;
      for (int w = 0; w < WAYS; w++) begin
         key_eq[w]  = (rd_row_ff[w].key == key_ff);
         era_eq[w]  = key_eq[w] && (rd_row_ff[w].value == value_ff);
         empty_w[w] = (rd_row_ff[w].value == EMPTY_VALUE);
         ng_w[w]    = !rd_row_ff[w].flags[FLAG_GOOD];
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (key_eq[w]) begin
            key_any = 1'b1;
            key_idx = WAY_W'(w);
         end
         if (era_eq[w]) begin
            era_any = 1'b1;
            era_idx = WAY_W'(w);
         end
         if (empty_w[w]) begin
            emp_any = 1'b1;
            emp_idx = WAY_W'(w);
         end
      end
      ng_cnt = CNT_W'($countones(ng_w));
   end

   always_comb begin
      exec_row    = rd_row_ff;
      exec_hit    = 1'b0;
      exec_fval   = EMPTY_VALUE;
      exec_fgood  = 1'b0;
      exec_wr     = 1'b0;
      exec_inc    = 1'b0;
      exec_dec    = 1'b0;
      need_victim = 1'b0;
      case (kind_ff)
         KIND_LOOKUP: begin
            if (key_any) begin
               exec_hit   = 1'b1;
               exec_fval  = rd_row_ff[key_idx].value;
               exec_fgood = rd_row_ff[key_idx].flags[FLAG_GOOD];
            end
         end
         KIND_INSERT: begin
            if (key_any) begin
               exec_row[key_idx].value           = value_ff;
               exec_row[key_idx].flags[FLAG_UPD] = 1'b1;
               if (good_ff) begin
                  exec_row[key_idx].flags[FLAG_GOOD] = 1'b1;
               end
               exec_hit = 1'b1;
               exec_wr  = 1'b1;
            end else if (emp_any) begin
               exec_row[emp_idx] = '{flags: {1'b0, good_ff}, value: value_ff, key: key_ff};
               exec_wr  = 1'b1;
               exec_inc = 1'b1;
            end else begin
               need_victim = 1'b1;
            end
         end
         KIND_ERASE: begin
            if (era_any) begin
               exec_row[era_idx] = EMPTY_ENTRY;
               exec_hit = 1'b1;
               exec_wr  = 1'b1;
               exec_dec = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Restoring modulo, MOD_STEP_BITS dividend bits per cycle.
   always_comb begin
      mod_r = rem_ff;
      mod_t = '0;
      for (int i = 0; i < MOD_STEP_BITS; i++) begin
         mod_t = {mod_r, dividend_ff[LFSR_W-1-i]};
         if (mod_t >= {1'b0, divisor_ff}) begin
            mod_t = mod_t - {1'b0, divisor_ff};
         end
         mod_r = mod_t[CNT_W-1:0];
      end
      rem_in = mod_r;
   end

   // The victim is the rem-th non-good way, or way rem after the good flags were dropped.
   always_comb begin
      victim = rem_ff[WAY_W-1:0];
      below  = '0;
      if (use_ng_ff) begin
         victim = '0;
         for (int w = 0; w < WAYS; w++) begin
            below = ngmask_ff & ~({WAYS{1'b1}} << w);
            if (ngmask_ff[w] && (CNT_W'($countones(below)) == rem_ff)) begin
               victim = WAY_W'(w);
            end
         end
      end
      pick_row = rd_row_ff;
      if (!use_ng_ff) begin
         for (int w = 0; w < WAYS; w++) begin
            pick_row[w].flags[FLAG_GOOD] = 1'b0;
         end
      end
      pick_row[victim] = '{flags: {1'b0, good_ff}, value: value_ff, key: key_ff};
   end

   always_comb begin
      lfsr_in = lfsr_ff;
      if (csr_wr_en) begin
         lfsr_in = (csr_wr_data == '0) ? LFSR_W'(1) : csr_wr_data;
      end else if ((state_ff == ST_EXEC) && need_victim) begin
         lfsr_in = lfsr_next;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: state_in = need_victim ? ST_MOD : ST_DONE;
         ST_MOD: begin
            if (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1)) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         lfsr_ff      <= LFSR_W'(1);
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         mod_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lfsr_ff  <= lfsr_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (state_ff == ST_EXEC) begin
            wr_pend_ff <= exec_wr;
            mod_cnt_ff <= '0;
         end else if (state_ff == ST_MOD) begin
            mod_cnt_ff <= mod_cnt_ff + 1'b1;
         end else if (state_ff == ST_PICK) begin
            wr_pend_ff <= 1'b1;
         end
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
            occ_ff       <= occ_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_tuser;
         key_ff   <= req_tdata[KEY_W-1:0];
         value_ff <= req_tdata[KEY_W +: VAL_W];
         good_ff  <= req_tdata[KEY_W + VAL_W];
      end
      if (state_ff == ST_HASH) begin
         hs_ff <= hash_front(key_ff);
      end
      if (state_ff == ST_READ) begin
         bucket_ff <= hash_c[LOG2_BUCKETS-1:0];
      end
      if (state_ff == ST_EXEC) begin
         wr_row_ff    <= exec_row;
         res_hit_ff   <= exec_hit;
         res_fval_ff  <= exec_fval;
         res_fgood_ff <= exec_fgood;
         res_repl_ff  <= need_victim;
         occ_inc_ff   <= exec_inc;
         occ_dec_ff   <= exec_dec;
         ngmask_ff    <= ng_w;
         use_ng_ff    <= (ng_cnt >= CNT_W'(2));
         divisor_ff   <= (ng_cnt >= CNT_W'(2)) ? ng_cnt : CNT_W'(WAYS);
         dividend_ff  <= lfsr_next;
         rem_ff       <= '0;
      end
      if (state_ff == ST_MOD) begin
         rem_ff      <= rem_in;
         dividend_ff <= dividend_ff << MOD_STEP_BITS;
      end
      if (state_ff == ST_PICK) begin
         wr_row_ff <= pick_row;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff <= {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, occ_in, res_repl_ff,
                         res_fgood_ff, res_fval_ff, res_hit_ff};
      end
   end

endmodule

### design/hsait_checker.sv
// Port-level checker of the hashed set-associative index table, bound to the table core.
module hsait_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [hsait_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import hsait_pkg::*;

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Reset starts the clearing pass, during which no request is taken.
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request ready right after reset");

   // One item at a time: the block is busy in the cycle after it takes a word.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request ready in the cycle after an accept");

   // A new result appears only as the item in flight completes.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while no item was in flight");

   // An insert that hit an existing key never reports a replacement.
   a_repl_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_HIT_BIT + VAL_W + 2] |-> !rsp_tdata[RSP_HIT_BIT])
      else $error("replacement reported together with a hit");

endmodule

bind hashed_set_assoc_index_table_core hsait_checker u_hsait_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/tb_hashed_set_assoc_index_table_core.sv
// Self-checking testbench for the hashed set-associative index table core.
`timescale 1ns / 100ps

module tb_hashed_set_assoc_index_table_core;
   import hsait_pkg::*;

   localparam int NBUCKET_BITS = DEF_LOG2_BUCKETS;
   localparam int NWAYS        = DEF_WAYS;
   localparam int NSLOTS       = (1 << NBUCKET_BITS) * NWAYS;
   localparam int HOT_BUCKETS  = 4;
   localparam int HOT_KEYS     = 14;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] fval;
      logic             fgood;
      logic             repl;
      logic [OCC_W-1:0] count;
   } table_reply_type;

   // One directed word; a pooled row takes its key from the hot-bucket pool by index.
   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
      logic             pooled;
      logic [VAL_W-1:0] val;
      logic             good;
      logic             typed;
      table_reply_type  want;
   } table_op_row_type;

   localparam table_reply_type NO_CHECK = '0;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_wr_en;
   logic [LFSR_W-1:0] csr_wr_data;

   // Shadow copy of the table contents, the occupancy and the victim LFSR.
   logic [KEY_W-1:0] tbl_key [NSLOTS];
   logic [VAL_W-1:0] tbl_val [NSLOTS];
   logic [1:0]       tbl_flags [NSLOTS];
   logic [OCC_W-1:0] occ_model;
   logic [LFSR_W-1:0] lfsr_model;

   logic [KEY_W-1:0] hot_keys [HOT_BUCKETS][HOT_KEYS];
   table_reply_type expected_replies [$];

   int req_idle_pct;
   int rsp_stall_pct;
   int phase_no;
   int mismatches;
   int words_sent;
   int replies_checked;
   int n_lookup_hits;
   int n_replaced;

   table_reply_type got_reply;
   table_reply_type want_reply;

   table_op_row_type directed_ops [25] = '{
      '{KIND_LOOKUP, 32'h0000_0000, 1'b0, 40'h0, 1'b0, 1'b1, '{1'b1, EMPTY_VALUE, 1'b0, 1'b0, 14'h0}},
      '{KIND_LOOKUP, 32'hffff_ffff, 1'b0, 40'h0, 1'b0, 1'b1, '{1'b0, EMPTY_VALUE, 1'b0, 1'b0, 14'h0}},
      '{KIND_NOP,    32'h0000_0005, 1'b0, 40'h0, 1'b1, 1'b1, '{1'b0, EMPTY_VALUE, 1'b0, 1'b0, 14'h0}},
      '{KIND_ERASE,  32'h0000_0000, 1'b0, EMPTY_VALUE, 1'b0, 1'b1,
        '{1'b1, EMPTY_VALUE, 1'b0, 1'b0, 14'h3fff}},
      '{KIND_INSERT, 32'hffff_ffff, 1'b0, 40'h0, 1'b0, 1'b1, '{1'b0, EMPTY_VALUE, 1'b0, 1'b0, 14'h0}},
      '{KIND_LOOKUP, 32'hffff_ffff, 1'b0, 40'h0, 1'b0, 1'b1, '{1'b1, 40'h0, 1'b0, 1'b0, 14'h0}},
      '{KIND_INSERT, 32'hffff_ffff, 1'b0, 40'hff_ffff_fffe, 1'b1, 1'b1,
        '{1'b1, EMPTY_VALUE, 1'b0, 1'b0, 14'h0}},
      '{KIND_LOOKUP, 32'hffff_ffff, 1'b0, 40'h0, 1'b0, 1'b1,
        '{1'b1, 40'hff_ffff_fffe, 1'b1, 1'b0, 14'h0}},
      '{KIND_ERASE,  32'hffff_ffff, 1'b0, 40'h0, 1'b0, 1'b1, '{1'b0, EMPTY_VALUE, 1'b0, 1'b0, 14'h0}},
      '{KIND_ERASE,  32'hffff_ffff, 1'b0, 40'hff_ffff_fffe, 1'b0, 1'b1,
        '{1'b1, EMPTY_VALUE, 1'b0, 1'b0, 14'h3fff}},
      '{KIND_INSERT, 32'h0000_0000, 1'b0, 40'h1, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'h0000_0001, 1'b0, EMPTY_VALUE, 1'b0, 1'b0, NO_CHECK},
      // Fill one hot bucket with protected entries, then overflow it twice.
      '{KIND_INSERT, 32'd0, 1'b1, 40'h00_0000_1000, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd1, 1'b1, 40'h00_0000_1001, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd2, 1'b1, 40'h00_0000_1002, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd3, 1'b1, 40'h00_0000_1003, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd4, 1'b1, 40'h00_0000_1004, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd5, 1'b1, 40'h00_0000_1005, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd6, 1'b1, 40'h00_0000_1006, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd7, 1'b1, 40'h00_0000_1007, 1'b1, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd8, 1'b1, 40'h80_0000_0000, 1'b0, 1'b0, NO_CHECK},
      '{KIND_INSERT, 32'd9, 1'b1, 40'h01_2345_6789, 1'b0, 1'b0, NO_CHECK},
      '{KIND_LOOKUP, 32'd0, 1'b1, 40'h0, 1'b0, 1'b0, NO_CHECK},
      '{KIND_LOOKUP, 32'd8, 1'b1, 40'h0, 1'b0, 1'b0, NO_CHECK},
      '{KIND_ERASE,  32'd9, 1'b1, 40'h01_2345_6789, 1'b0, 1'b0, NO_CHECK}
   };

   hashed_set_assoc_index_table_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input int k);
      return (x << k) | (x >> (32 - k));
   endfunction

   function automatic int bucket_of(input logic [KEY_W-1:0] key);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      a = HASH_SEED + key;
      b = HASH_SEED;
      c = HASH_SEED;
      c = (c ^ b) - rol(b, 14);
      a = (a ^ c) - rol(c, 11);
      b = (b ^ a) - rol(a, 25);
      c = (c ^ b) - rol(b, 16);
      a = (a ^ c) - rol(c, 4);
      b = (b ^ a) - rol(a, 14);
      c = (c ^ b) - rol(b, 24);
      return int'(c[NBUCKET_BITS-1:0]);
   endfunction

   function automatic void step_lfsr();
      lfsr_model = {1'b0, lfsr_model[LFSR_W-1:1]} ^ (lfsr_model[0] ? LFSR_TAPS : '0);
   endfunction

   // Applies one word to the shadow table and returns the reply it should produce.
   function automatic table_reply_type apply_table_op(input logic [1:0] kind,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [VAL_W-1:0] val,
                                                      input logic good);
      table_reply_type r;
      int base;
      int w;
      int slot;
      int unsigned n;
      logic [31:0] pick;
      logic found;
      r = '{1'b0, EMPTY_VALUE, 1'b0, 1'b0, '0};
      base = bucket_of(key) * NWAYS;
      found = 1'b0;
      slot = -1;
      case (kind)
         KIND_LOOKUP: begin
            for (w = 0; w < NWAYS && !found; w++) begin
               if (tbl_key[base+w] == key) begin
                  found = 1'b1;
                  r.hit = 1'b1;
                  r.fval = tbl_val[base+w];
                  r.fgood = tbl_flags[base+w][FLAG_GOOD];
                  n_lookup_hits++;
               end
            end
         end
         KIND_INSERT: begin
            for (w = 0; w < NWAYS && !found; w++) begin
               if (tbl_key[base+w] == key) begin
                  found = 1'b1;
                  r.hit = 1'b1;
                  tbl_val[base+w] = val;
                  tbl_flags[base+w][FLAG_UPD] = 1'b1;
                  if (good) tbl_flags[base+w][FLAG_GOOD] = 1'b1;
               end else if (slot < 0 && tbl_val[base+w] == EMPTY_VALUE) begin
                  slot = w;
               end
            end
            if (!found) begin
               if (slot >= 0) begin
                  occ_model = occ_model + 1'b1;
               end else begin
                  n = 0;
                  for (w = 0; w < NWAYS; w++)
                     if (!tbl_flags[base+w][FLAG_GOOD]) n++;
                  if (n >= 2) begin
                     step_lfsr();
                     pick = lfsr_model % n;
                     for (w = 0; w < NWAYS && slot < 0; w++) begin
                        if (!tbl_flags[base+w][FLAG_GOOD]) begin
                           if (pick == 0) slot = w;
                           else pick--;
                        end
                     end
                  end else begin
                     // Too few unprotected ways left: drop protection bucket-wide.
                     for (w = 0; w < NWAYS; w++) tbl_flags[base+w][FLAG_GOOD] = 1'b0;
                     step_lfsr();
                     slot = int'(lfsr_model % NWAYS);
                  end
                  r.repl = 1'b1;
                  n_replaced++;
               end
               tbl_key[base+slot] = key;
               tbl_val[base+slot] = val;
               tbl_flags[base+slot] = {1'b0, good};
            end
         end
         KIND_ERASE: begin
            for (w = 0; w < NWAYS && !found; w++) begin
               if (tbl_key[base+w] == key && tbl_val[base+w] == val) begin
                  found = 1'b1;
                  r.hit = 1'b1;
                  tbl_key[base+w] = '0;
                  tbl_val[base+w] = EMPTY_VALUE;
                  tbl_flags[base+w] = 2'b00;
                  occ_model = occ_model - 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.count = occ_model;
      return r;
   endfunction

   // Offers one word, waits for it to be taken, and queues the reply it should produce.
   task automatic issue_op(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val, input logic good,
                           input logic typed, input table_reply_type want);
      table_reply_type model_reply;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, good, val, key};
      do @(posedge clock); while (!req_tready);
      model_reply = apply_table_op(kind, key, val, good);
      expected_replies = {expected_replies, typed ? want : model_reply};
      words_sent++;
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      // An overflowing insert keeps the block busy through the victim choice.
      repeat (20) @(posedge clock);
   endtask

   task automatic write_seed(input logic [LFSR_W-1:0] seed);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seed;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      lfsr_model = (seed != 0) ? seed : 32'd1;
   endtask

   task automatic run_random(input int count);
      logic [1:0] kind;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
      logic [63:0] raw;
      logic good;
      int pick;
      int base;
      int w;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         kind = (pick < 35) ? KIND_LOOKUP : (pick < 75) ? KIND_INSERT :
                (pick < 94) ? KIND_ERASE : KIND_NOP;
         // Most keys land in a few crowded buckets so that victims get picked often.
         pick = $urandom_range(99);
         if (pick < 72) key = hot_keys[$urandom_range(HOT_BUCKETS-1)][$urandom_range(HOT_KEYS-1)];
         else if (pick < 80) key = '0;
         else key = $urandom();
         raw = {$urandom(), $urandom()};
         pick = $urandom_range(99);
         val = (pick < 4) ? EMPTY_VALUE : (pick < 8) ? '0 : raw[VAL_W-1:0];
         good = ($urandom_range(99) < 40);
         if (kind == KIND_ERASE && $urandom_range(99) < 75) begin
            base = bucket_of(key) * NWAYS;
            for (w = NWAYS - 1; w >= 0; w--)
               if (tbl_key[base+w] == key) val = tbl_val[base+w];
         end
         issue_op(kind, key, val, good, 1'b0, NO_CHECK);
      end
   endtask

   task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_reply = {rsp_tdata[0], rsp_tdata[40:1], rsp_tdata[41], rsp_tdata[42],
                      rsp_tdata[56:43]};
         if (expected_replies.size() == 0) begin
            $display("%0t: reply word with none expected, expected nothing, got %0h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want_reply = expected_replies.pop_front();
            check_field("hit", want_reply.hit, got_reply.hit);
            check_field("found_value", want_reply.fval, got_reply.fval);
            check_field("found_good", want_reply.fgood, got_reply.fgood);
            check_field("replaced", want_reply.repl, got_reply.repl);
            check_field("entry_count", want_reply.count, got_reply.count);
            replies_checked++;
         end
      end
   end

   // Reply side: random stalls, plus one long hold at the start of the last phase.
   initial begin
      int hold_left;
      bit held;
      rsp_tready = 1'b0;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (phase_no == 3 && !held) begin
            held = 1'b1;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int hot_bucket [HOT_BUCKETS];
      int hot_fill [HOT_BUCKETS];
      int filled;
      int bk;
      logic [KEY_W-1:0] cand;
      logic [KEY_W-1:0] key;
      table_op_row_type row;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_NOP;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      phase_no = 0;
      req_idle_pct = 28;
      rsp_stall_pct = 85;
      mismatches = 0;
      words_sent = 0;
      replies_checked = 0;
      n_lookup_hits = 0;
      n_replaced = 0;

      for (int i = 0; i < NSLOTS; i++) begin
         tbl_key[i] = '0;
         tbl_val[i] = EMPTY_VALUE;
         tbl_flags[i] = 2'b00;
      end
      occ_model = '0;
      lfsr_model = 32'd1;

      // Gather keys that share a handful of buckets.
      for (int b = 0; b < HOT_BUCKETS; b++) begin
         hot_bucket[b] = bucket_of($urandom());
         hot_fill[b] = 0;
      end
      filled = 0;
      while (filled < HOT_BUCKETS * HOT_KEYS) begin
         cand = $urandom();
         bk = bucket_of(cand);
         for (int b = 0; b < HOT_BUCKETS; b++) begin
            if (bk == hot_bucket[b] && hot_fill[b] < HOT_KEYS) begin
               hot_keys[b][hot_fill[b]] = cand;
               hot_fill[b]++;
               filled++;
               break;
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      phase_no = 1;
      write_seed($urandom() | 32'd1);
      foreach (directed_ops[i]) begin
         row = directed_ops[i];
         key = row.pooled ? hot_keys[0][row.key] : row.key;
         issue_op(row.kind, key, row.val, row.good, row.typed, row.want);
      end
      write_seed(32'd1);
      run_random(250);

      phase_no = 2;
      req_idle_pct = 85;
      rsp_stall_pct = 28;
      write_seed(32'hffff_ffff);
      run_random(250);

      req_idle_pct = 0;
      rsp_stall_pct = 0;
      write_seed($urandom() | 32'd1);
      phase_no = 3;
      run_random(250);

      drain_replies();
      $display("Sent %0d words under four seed loads and three idle mixes, with one long hold.",
               words_sent);
      $display("Checked %0d replies; %0d lookup hits and %0d victim overwrites were predicted.",
               replies_checked, n_lookup_hits, n_replaced);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
